// ===== src/gmc_pkg.sv =====
// Shared types, register indexes and compare helper for the morphological close block.
// No dependencies; imported by every module of the block except gmc_ram.
package gmc_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Register reset values
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [10:0] RST_HEIGHT = 11'd480;
    localparam logic [1:0]  RST_RADIUS = 2'd1;

    // Item sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S0_RD,
        ST_S0_VERT,
        ST_S0_FIN,
        ST_S1_RD,
        ST_S1_VERT,
        ST_S1_FIN,
        ST_EMIT
    } t_state;

    // Per-item strobes from the sequencer to one window stage
    typedef struct packed {
        logic rd;
        logic vert;
        logic fin;
        logic clr;
    } t_stg_ctl;

    // Status of one window stage
    typedef struct packed {
        logic       started;
        logic       p_in_frame;
        logic       got;
        logic       last;
        logic [7:0] res;
    } t_stg_st;

    // Larger of two values for dilation, smaller for erosion
    function automatic logic [7:0] f_pick(input logic take_max, input logic [7:0] a,
                                          input logic [7:0] b);
        if (take_max) return (a > b) ? a : b;
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== src/gmc_ram.sv =====
// Generic one-write, two-read RAM with registered read data.
// No dependencies.
module gmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read two
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== src/gmc_cell.sv =====
// One window cell: holds one column extreme, hands it to its neighbor on a shift,
// and folds it into the running extreme of the chain. Uses gmc_pkg.
module gmc_cell (
    input  logic       i_clk,
    input  logic       i_take_max,
    input  logic       i_shift,
    input  logic [7:0] i_din,
    input  logic       i_active,
    input  logic [7:0] i_acc,
    output logic [7:0] o_q,
    output logic [7:0] o_acc
);
    import gmc_pkg::*;

    logic [7:0] r_q;

    // Advance the column extreme along the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_din;
        end
    end

    // Fold this cell into the window extreme when it lies inside the window
    assign o_acc = i_active ? f_pick(i_take_max, i_acc, r_q) : i_acc;
    assign o_q   = r_q;
endmodule

// ===== src/gmc_stage.sv =====
// One window stage (max for dilation, min for erosion): line buffers, position
// counters and a chain of window cells. Uses gmc_pkg, gmc_ram, gmc_cell.
module gmc_stage #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3,
    parameter bit TAKE_MAX   = 1'b1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gmc_pkg::t_stg_ctl                      i_ctl,
    input  logic [7:0]                             i_val,
    input  logic                                   i_valid,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]        i_h,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]        i_r,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT
                  + 2*(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS)+1)-1:0] i_d,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT
                  + 2*(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS)+1)-1:0] i_total,
    output gmc_pkg::t_stg_st                       o_st
);
    import gmc_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int NR  = 2 * MAX_RADIUS;
    localparam int GW  = $clog2(NR);
    localparam int NC  = 2 * MAX_RADIUS + 1;
    localparam int LW  = $clog2(MAX_WIDTH*MAX_HEIGHT + 2*(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS) + 1);

    logic [7:0]    r_val;
    logic          r_valid;
    logic [LW-1:0] r_plin, r_qlin;
    logic [CW-1:0] r_pcol, r_qx;
    logic [YW-1:0] r_qy;
    logic [GW-1:0] r_pring, r_qring;
    logic [7:0]    r_border;
    logic          r_got, r_last;
    logic [7:0]    r_res;

    logic [7:0]  w_rda [NR];
    logic [7:0]  w_rdb [NR];
    logic [7:0]  w_q   [NC];
    logic [7:0]  w_acc [NC];
    logic [7:0]  w_vert;
    logic [RW:0] w_rows;
    logic        w_started, w_qin, w_inner;
    logic        w_pcol_wrap, w_qx_wrap;
    logic [GW-1:0] w_ring_last;

    assign w_rows      = {i_r, 1'b0};
    assign w_ring_last = GW'(w_rows - 1'b1);

    // Line buffers, one per ring row
    for (genvar g = 0; g < NR; g++) begin : g_row
        gmc_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
            .i_clk    (i_clk),
            .i_we     (i_ctl.vert && r_valid && (r_pring == GW'(g))),
            .i_waddr  (r_pcol),
            .i_wdata  (r_val),
            .i_raddr_a(r_pcol),
            .i_raddr_b(r_qx),
            .o_rdata_a(w_rda[g]),
            .o_rdata_b(w_rdb[g])
        );
    end

    // Fold the stored rows of this column into the new pixel
    always_comb begin
        w_vert = r_val;
        for (int i = 0; i < NR; i++) begin
            if ((RW+1)'(i) < w_rows) begin
                w_vert = f_pick(TAKE_MAX, w_vert, w_rda[i]);
            end
        end
    end

    // Window cells, newest column in cell 0
    for (genvar g = 0; g < NC; g++) begin : g_cell
        gmc_cell u_cell (
            .i_clk     (i_clk),
            .i_take_max(TAKE_MAX),
            .i_shift   (i_ctl.vert && r_valid),
            .i_din     ((g == 0) ? w_vert : w_q[(g == 0) ? 0 : g-1]),
            .i_active  ((RW+1)'(g) <= w_rows),
            .i_acc     ((g == 0) ? w_q[0] : w_acc[(g == 0) ? 0 : g-1]),
            .o_q       (w_q[g]),
            .o_acc     (w_acc[g])
        );
    end

    assign w_started   = (r_plin >= i_d);
    assign w_qin       = (r_qlin < i_total);
    assign w_inner     = ((HW+1)'(r_qy) >= (HW+1)'(i_r))
                      && ((HW+1)'(r_qy) + (HW+1)'(i_r) < (HW+1)'(i_h))
                      && ((WW+1)'(r_qx) >= (WW+1)'(i_r))
                      && ((WW+1)'(r_qx) + (WW+1)'(i_r) < (WW+1)'(i_w));
    assign w_pcol_wrap = ((WW+1)'(r_pcol) + 1'b1 == (WW+1)'(i_w));
    assign w_qx_wrap   = ((WW+1)'(r_qx) + 1'b1 == (WW+1)'(i_w));

    // Payload: input word, border value, result
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_val <= i_val;
        end
        if (i_ctl.vert) begin
            r_border <= w_rdb[r_qring];
        end
        if (i_ctl.fin) begin
            if (i_r == '0) begin
                r_res <= r_val;
            end else if (w_inner) begin
                r_res <= w_acc[NC-1];
            end else begin
                r_res <= r_border;
            end
            r_last <= ((YW+1)'(r_qy) + 1'b1 == (YW+1)'(i_h)) && w_qx_wrap;
        end
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_valid <= 1'b0;
            r_got   <= 1'b0;
            r_plin  <= '0;
            r_pcol  <= '0;
            r_pring <= '0;
            r_qlin  <= '0;
            r_qx    <= '0;
            r_qy    <= '0;
            r_qring <= '0;
        end else begin
            if (i_ctl.rd) begin
                r_valid <= i_valid;
            end
            if (i_ctl.fin) begin
                r_got  <= w_started && w_qin;
                r_plin <= r_plin + 1'b1;
                if (w_pcol_wrap) begin
                    r_pcol <= '0;
                    if (i_r != '0) begin
                        r_pring <= (r_pring == w_ring_last) ? '0 : r_pring + 1'b1;
                    end
                end else begin
                    r_pcol <= r_pcol + 1'b1;
                end
                if (w_started) begin
                    r_qlin <= r_qlin + 1'b1;
                    if (w_qx_wrap) begin
                        r_qx <= '0;
                        r_qy <= r_qy + 1'b1;
                        if (i_r != '0) begin
                            r_qring <= (r_qring == w_ring_last) ? '0 : r_qring + 1'b1;
                        end
                    end else begin
                        r_qx <= r_qx + 1'b1;
                    end
                end
            end
        end
    end

    assign o_st.started    = w_started;
    assign o_st.p_in_frame = (r_plin < i_total);
    assign o_st.got        = r_got;
    assign o_st.last       = r_last;
    assign o_st.res        = r_res;
endmodule

// ===== src/grayscale_morphological_close.sv =====
// Grayscale closing with a square window: dilation stage, then erosion stage.
// Uses gmc_pkg, gmc_stage (which uses gmc_ram and gmc_cell).
//
// Usage:
//   Slave stream: one word per raster pixel, tdata = pixel_in, tuser = drain.
//   After the last pixel of a frame, send drain words (or extra pixels, which
//   are dropped) to push out the tail; a drain word inside the frame is ignored.
//   Master stream: tdata = closed pixel, tlast = last pixel of the frame.
//   Each stage lags by r*W + r positions, so the result for pixel q leaves on
//   the word that is 2*(r*W + r) words after it.
//   Each word passes, in each stage, through buffer read, column fold and window
//   fold, then a hand-over step; a drain word inside the frame takes no step, and
//   one that only feeds the first stage ends after that stage's window fold. The
//   block takes no new word until it is through with the last one.
//   The APB port holds image_width (0x0), image_height (0x4), kernel_radius
//   (0x8); a write restarts the frame. Write only while the block is idle.
//   Reset: registers take 640, 480, 1 and the frame position returns to zero;
//   no clearing pass is needed.
//   A stalled receiver holds the result register; the block takes the next
//   word and works it up to the hand-over step, then waits.
module grayscale_morphological_close #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tuser,   // [0] drain
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gmc_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int LW = $clog2(MAX_WIDTH*MAX_HEIGHT + 2*(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS) + 1);

    logic [10:0] r_cfg_w, r_cfg_h;
    logic [1:0]  r_cfg_r;
    t_state      r_state, n_state;
    logic [7:0]  r_px;
    logic        r_pvalid;
    logic        r_m_valid, r_m_last;
    logic [7:0]  r_m_data;

    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;
    logic [RW-1:0] w_r;
    logic [LW-1:0] w_total, w_d;
    logic          w_cfg_wr, w_cfg_hit, w_accept, w_load, w_last_clr;
    t_stg_ctl      w_ctl0, w_ctl1;
    t_stg_st       w_st0, w_st1;

    // Configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_hit = w_cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT
                                    || paddr[3:2] == REG_RADIUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_r <= RST_RADIUS;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_cfg_w <= pwdata[10:0];
                REG_HEIGHT: r_cfg_h <= pwdata[10:0];
                REG_RADIUS: r_cfg_r <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {21'd0, r_cfg_w};
            REG_HEIGHT: prdata = {21'd0, r_cfg_h};
            REG_RADIUS: prdata = {30'd0, r_cfg_r};
            default:    prdata = '0;
        endcase
    end

    // Clamp registers to the supported frame and window
    always_comb begin
        if (r_cfg_w == '0)                  w_w = WW'(1);
        else if (int'(r_cfg_w) > MAX_WIDTH) w_w = WW'(MAX_WIDTH);
        else                                w_w = WW'(r_cfg_w);
        if (r_cfg_h == '0)                   w_h = HW'(1);
        else if (int'(r_cfg_h) > MAX_HEIGHT) w_h = HW'(MAX_HEIGHT);
        else                                 w_h = HW'(r_cfg_h);
        if (int'(r_cfg_r) > MAX_RADIUS) w_r = RW'(MAX_RADIUS);
        else                            w_r = RW'(r_cfg_r);
    end

    assign w_total = LW'(w_w) * LW'(w_h);
    assign w_d     = LW'(w_r) * LW'(w_w) + LW'(w_r);

    // Input word latch
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px     <= s_axis_tdata;
            r_pvalid <= w_st0.p_in_frame;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and stage strobes
    always_comb begin
        n_state    = r_state;
        w_ctl0     = '0;
        w_ctl1     = '0;
        w_load     = 1'b0;
        w_last_clr = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !(w_st0.p_in_frame && s_axis_tuser)) begin
                    n_state = ST_S0_RD;
                end
            end
            ST_S0_RD: begin
                w_ctl0.rd = 1'b1;
                n_state   = ST_S0_VERT;
            end
            ST_S0_VERT: begin
                w_ctl0.vert = 1'b1;
                n_state     = ST_S0_FIN;
            end
            ST_S0_FIN: begin
                w_ctl0.fin = 1'b1;
                n_state    = w_st0.started ? ST_S1_RD : ST_IDLE;
            end
            ST_S1_RD: begin
                w_ctl1.rd = 1'b1;
                n_state   = ST_S1_VERT;
            end
            ST_S1_VERT: begin
                w_ctl1.vert = 1'b1;
                n_state     = ST_S1_FIN;
            end
            ST_S1_FIN: begin
                w_ctl1.fin = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!w_st1.got) begin
                    n_state = ST_IDLE;
                end else if (!r_m_valid || m_axis_tready) begin
                    w_load     = 1'b1;
                    w_last_clr = w_st1.last;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        w_ctl0.clr = w_cfg_hit || w_last_clr;
        w_ctl1.clr = w_cfg_hit || w_last_clr;
    end

    gmc_stage #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS),
        .TAKE_MAX(1'b1)
    ) u_dilate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl0),
        .i_val(r_px), .i_valid(r_pvalid),
        .i_w(w_w), .i_h(w_h), .i_r(w_r), .i_d(w_d), .i_total(w_total),
        .o_st(w_st0)
    );

    gmc_stage #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS),
        .TAKE_MAX(1'b0)
    ) u_erode (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl1),
        .i_val(w_st0.res), .i_valid(w_st0.got),
        .i_w(w_w), .i_h(w_h), .i_r(w_r), .i_d(w_d), .i_total(w_total),
        .o_st(w_st1)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= w_st1.res;
            r_m_last <= w_st1.last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // Erosion runs only on words whose position reached the first stage's lag
    a_s1_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S0_FIN && !w_st0.started) |=> (r_state == ST_IDLE))
        else $error("erosion stage entered before dilation output started");

    // Hold a finished result while the output register is still full
    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_st1.got && r_m_valid && !m_axis_tready)
        |=> (r_state == ST_EMIT))
        else $error("result dropped while output stalled");

    // A loaded result always shows on the master side next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (m_axis_tvalid && m_axis_tdata == $past(w_st1.res)))
        else $error("output register not loaded");

    // The frame end clears the dilation position
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_clr |=> (w_st0.p_in_frame || w_total == '0))
        else $error("frame position not cleared after frame end");
endmodule
